// ===== src/signed_radix_digit_emitter_top_defines.svh =====
`ifndef SIGNED_RADIX_DIGIT_EMITTER_TOP_DEFINES_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SRDE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SRDE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/srde_pkg.sv =====
package srde_pkg;

    localparam int NUM_W        = 32;
    localparam int MAG_W        = NUM_W + 1;
    localparam int CHAR_W       = 8;
    localparam int LEN_W        = 6;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int SYM_WORDS    = 4;
    localparam int SYMS_PER_WORD = CFG_W / CHAR_W;
    localparam int MAX_BASE_DEF = 32;
    localparam int MIN_BASE     = 2;

    // Digit stack depth; the longest digit string is 2**31 in base two.
    localparam int MAX_DIGITS   = MAG_W;

    // Quotient bits resolved per divider cycle.
    localparam int DIV_STEP     = 8;
    localparam int DIV_CHUNKS   = (MAG_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W        = DIV_CHUNKS * DIV_STEP;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_3   = 3'd4;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    typedef struct packed {
        logic start;
        logic sweep_inc;
        logic div_step;
        logic digit_write;
        logic load_sign;
        logic load_digit;
        logic out_take;
    } srde_cmd_t;

    typedef struct packed {
        logic len_ok;
        logic sym_bad;
        logic sweep_end;
        logic chunk_last;
        logic quot_zero;
        logic nd_full;
        logic neg;
        logic out_last;
    } srde_status_t;

endpackage

// ===== src/srde_ram.sv =====
module srde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/srde_datapath.sv =====
module srde_datapath
    import srde_pkg::*;
#(
    parameter int MAX_BASE = MAX_BASE_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_wdata,
    input  logic signed [NUM_W-1:0] number,
    output logic [CHAR_W-1:0]       character,
    output logic                    last,
    output logic                    out_valid,
    input  srde_cmd_t               cmd,
    output srde_status_t            status
);

    localparam int DIG_W   = $clog2(MAX_BASE);
    localparam int ADDR_W  = $clog2(MAX_DIGITS);
    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int CHUNK_W = $clog2(DIV_CHUNKS);

    logic [LEN_W-1:0]  base_length_reg;
    logic [CFG_W-1:0]  sym_words_reg [SYM_WORDS];
    logic [CHAR_W-1:0] sym [MAX_BASE];

    logic [DIG_W-1:0]   sweep_idx_reg;
    logic               neg_reg;
    logic [DIV_W-1:0]   work_reg;
    logic [DIV_W-1:0]   work_next;
    logic [DIG_W-1:0]   rem_reg;
    logic [DIG_W-1:0]   rem_next;
    logic [CHUNK_W-1:0] chunk_reg;
    logic [CNT_W-1:0]   nd_reg;
    logic [ADDR_W-1:0]  rd_ptr_reg;
    logic [DIG_W-1:0]   rd_digit;

    logic               out_valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    logic [CHAR_W-1:0]  sym_cur;
    logic [MAX_BASE-1:0] dup_vec;
    logic [LEN_W-1:0]   len_m1;
    logic [DIG_W:0]     len_div;
    logic [MAG_W-1:0]   num_ext;
    logic [MAG_W-1:0]   mag;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_length_reg <= '0;
            for (int w = 0; w < SYM_WORDS; w++)
            begin
                sym_words_reg[w] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BASE_LENGTH: base_length_reg  <= cfg_wdata[LEN_W-1:0];
                REG_SYMBOLS_0:   sym_words_reg[0] <= cfg_wdata;
                REG_SYMBOLS_1:   sym_words_reg[1] <= cfg_wdata;
                REG_SYMBOLS_2:   sym_words_reg[2] <= cfg_wdata;
                REG_SYMBOLS_3:   sym_words_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    for (genvar gi = 0; gi < MAX_BASE; gi++)
    begin : g_sym
        assign sym[gi] = sym_words_reg[gi / SYMS_PER_WORD][(gi % SYMS_PER_WORD) * CHAR_W +: CHAR_W];
    end

    // alphabet check, one symbol per cycle against all later ones
    assign sym_cur = sym[sweep_idx_reg];
    assign len_m1  = base_length_reg - LEN_W'(1);

    always_comb
    begin
        for (int j = 0; j < MAX_BASE; j++)
        begin
            dup_vec[j] = (DIG_W'(j) > sweep_idx_reg) && (LEN_W'(j) < base_length_reg)
                         && (sym[j] == sym_cur);
        end
    end

    // magnitude in 33 bits so that the most negative number is exact
    assign num_ext = {number[NUM_W-1], number};
    assign mag     = number[NUM_W-1] ? (~num_ext + MAG_W'(1)) : num_ext;

    // restoring division, DIV_STEP quotient bits per cycle
    assign len_div = base_length_reg[DIG_W:0];

    always_comb
    begin
        logic [DIG_W:0]   t;
        logic [DIG_W:0]   sub;
        logic [DIG_W-1:0] r;
        logic [DIV_W-1:0] w;
        logic             q;
        r = rem_reg;
        w = work_reg;
        for (int k = 0; k < DIV_STEP; k++)
        begin
            t   = {r, w[DIV_W-1]};
            sub = t - len_div;
            q   = (t >= len_div);
            r   = q ? sub[DIG_W-1:0] : t[DIG_W-1:0];
            w   = {w[DIV_W-2:0], q};
        end
        rem_next  = r;
        work_next = w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_idx_reg <= '0;
            chunk_reg     <= '0;
            nd_reg        <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                sweep_idx_reg <= '0;
                chunk_reg     <= '0;
                nd_reg        <= '0;
            end
            if (cmd.sweep_inc)
            begin
                sweep_idx_reg <= sweep_idx_reg + DIG_W'(1);
            end
            if (cmd.div_step)
            begin
                chunk_reg <= chunk_reg + CHUNK_W'(1);
            end
            if (cmd.digit_write)
            begin
                chunk_reg  <= '0;
                nd_reg     <= nd_reg + CNT_W'(1);
                rd_ptr_reg <= nd_reg[ADDR_W-1:0];
            end
            if (cmd.load_digit)
            begin
                rd_ptr_reg <= rd_ptr_reg - ADDR_W'(1);
            end
            if (cmd.load_sign || cmd.load_digit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cmd.out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            neg_reg  <= number[NUM_W-1];
            work_reg <= {{(DIV_W - MAG_W){1'b0}}, mag};
            rem_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
        if (cmd.digit_write)
        begin
            rem_reg <= '0;
        end
        if (cmd.load_sign)
        begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end
        if (cmd.load_digit)
        begin
            char_reg <= sym[rd_digit];
            last_reg <= (rd_ptr_reg == '0);
        end
    end

    // digit stack, written least significant first, read back in reverse
    srde_ram #(
        .WIDTH (DIG_W),
        .DEPTH (MAX_DIGITS)
    ) u_digit_ram (
        .clk   (clk),
        .we    (cmd.digit_write),
        .waddr (nd_reg[ADDR_W-1:0]),
        .wdata (rem_reg),
        .raddr (rd_ptr_reg),
        .rdata (rd_digit)
    );

    assign status.len_ok = (base_length_reg >= LEN_W'(MIN_BASE))
                           && (base_length_reg <= LEN_W'(MAX_BASE));
    assign status.sym_bad = (sym_cur == CHAR_PLUS) || (sym_cur == CHAR_MINUS)
                            || (sym_cur == CHAR_SPACE) || (sym_cur == CHAR_NUL)
                            || (|dup_vec);
    assign status.sweep_end  = (sweep_idx_reg == len_m1[DIG_W-1:0]);
    assign status.chunk_last = (chunk_reg == CHUNK_W'(DIV_CHUNKS - 1));
    assign status.quot_zero  = (work_reg == '0);
    assign status.nd_full    = (nd_reg == CNT_W'(MAX_DIGITS - 1));
    assign status.neg        = neg_reg;
    assign status.out_last   = last_reg;

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

// ===== src/srde_ctrl.sv =====
module srde_ctrl
    import srde_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         out_ready,
    output srde_cmd_t    cmd,
    input  srde_status_t status
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CHECK = 4'd1;
    localparam logic [3:0] ST_SWEEP = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_DWR   = 4'd4;
    localparam logic [3:0] ST_SIGN  = 4'd5;
    localparam logic [3:0] ST_RD    = 4'd6;
    localparam logic [3:0] ST_LD    = 4'd7;
    localparam logic [3:0] ST_SEND  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.len_ok ? ST_SWEEP : ST_IDLE;
            end
            ST_SWEEP:
            begin
                if (status.sym_bad)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.sweep_end)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    cmd.sweep_inc = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.chunk_last)
                begin
                    state_next = ST_DWR;
                end
            end
            ST_DWR:
            begin
                cmd.digit_write = 1'b1;
                if (status.quot_zero || status.nd_full)
                begin
                    state_next = status.neg ? ST_SIGN : ST_RD;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_SIGN:
            begin
                cmd.load_sign = 1'b1;
                state_next    = ST_SEND;
            end
            ST_RD:
            begin
                state_next = ST_LD;
            end
            ST_LD:
            begin
                cmd.load_digit = 1'b1;
                state_next     = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_ready)
                begin
                    cmd.out_take = 1'b1;
                    state_next   = status.out_last ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// ===== src/signed_radix_digit_emitter_top.sv =====
// Signed radix digit emitter: takes one signed 32-bit number per request and
// sends it out as a string of 8-bit characters in the radix held in
// base_length (register 0), using the alphabet packed one byte per symbol in
// registers 1 to 4 (symbol 0 in the low byte of register 1). A negative number
// starts with '-', digits follow most significant first, and last marks the
// final character. The most negative number converts exactly. If the alphabet
// is invalid (length below 2 or above MAX_BASE, a '+', '-', space or zero byte
// among the used symbols, or a symbol used twice) the request is consumed and
// nothing is sent. One request is in flight at a time: in_ready is high only
// while the block is idle. A request passes through a length check, then a
// check of each used alphabet symbol in turn, then for each digit a shared
// divider resolving 8 quotient bits per cycle followed by a push of the digit
// onto the digit stack RAM, then for each digit character sent a stack read,
// a load and a hand-off, and for a leading minus a load and a hand-off; the
// hand-off waits while out_ready is held low. No clearing pass follows reset.
module signed_radix_digit_emitter_top
    import srde_pkg::*;
#(
    parameter int MAX_BASE = MAX_BASE_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration write port
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_wdata,
    // number request
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [NUM_W-1:0] number,
    // character results
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CHAR_W-1:0]       character,
    output logic                    last
);

    srde_cmd_t    cmd;
    srde_status_t status;

    // sequencer: check alphabet, divide, then drain the digit stack
    srde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // registers, divider, digit stack and output register
    srde_datapath #(
        .MAX_BASE (MAX_BASE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .number    (number),
        .character (character),
        .last      (last),
        .out_valid (out_valid),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== src/srde_checker.sv =====
`include "signed_radix_digit_emitter_top_defines.svh"

module srde_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] character,
    input logic       last
);

    // only one request in flight: never ready for input while a character waits
    `SRDE_ASSERT_SAME(a_no_overlap, in_ready, !out_valid, "input ready while output valid")

    // a taken request takes the block out of idle, so in_ready drops
    `SRDE_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready right after request")

    // the final character returns the block to idle
    `SRDE_ASSERT_NEXT(a_idle_after_last, out_valid && out_ready && last, in_ready, "not idle after last")

    // a stalled character holds
    `SRDE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(character) && $stable(last), "stalled output changed")

endmodule

bind signed_radix_digit_emitter_top srde_checker u_srde_checker (.*);
